// File: rtl/generations_ca_cell_rule_engine_assert.svh
`ifndef GENERATIONS_CA_CELL_RULE_ENGINE_ASSERT_SVH
`define GENERATIONS_CA_CELL_RULE_ENGINE_ASSERT_SVH

// Same-cycle implication, sampled on clk and disabled while arst_n is low.
`define GCRE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, sampled on clk and disabled while arst_n is low.
`define GCRE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: rtl/gcre_pkg.sv
`default_nettype none

package gcre_pkg;

	localparam int TBL_DEPTH = 512;
	localparam int TBL_AW    = 9;
	localparam int TBL_WIDTH = 1;
	localparam int DONE_W    = 18;

	localparam logic [8:0] CENTER_BIT = 9'h010;
	localparam logic [8:0] MIRROR_XOR = 9'h1ef;
	localparam logic [8:0] NS_RESET   = 9'd3;
	localparam logic [8:0] MASK_RESET = 9'd511;

	typedef enum logic [1:0] {
		CMD_CLEAR  = 2'd0,
		CMD_COUNT  = 2'd1,
		CMD_LETTER = 2'd2,
		CMD_EVAL   = 2'd3
	} cmd_t;

	typedef enum logic {
		CFG_NUM_STATES    = 1'b0,
		CFG_NEIGHBOR_MASK = 1'b1
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_TOTAL,
		ST_LETTER
	} fsm_t;

	localparam logic [8:0] ISO_C1 [2]  = '{9'd1, 9'd2};
	localparam logic [8:0] ISO_C2 [6]  = '{9'd5, 9'd10, 9'd3, 9'd40, 9'd33, 9'd68};
	localparam logic [8:0] ISO_C3 [10] = '{9'd69, 9'd42, 9'd11, 9'd7, 9'd98, 9'd13, 9'd14,
		9'd70, 9'd41, 9'd97};
	localparam logic [8:0] ISO_C4 [13] = '{9'd325, 9'd170, 9'd15, 9'd45, 9'd99, 9'd71,
		9'd106, 9'd102, 9'd43, 9'd101, 9'd105, 9'd78, 9'd108};
	localparam logic [3:0] ISO_LEN [4] = '{4'd2, 4'd6, 4'd10, 4'd13};

	function automatic logic [3:0] pop9(input logic [8:0] v);
		logic [3:0] n;
		n = '0;
		for (int k = 0; k < 9; k++) begin
			n = n + {3'b000, v[k]};
		end
		return n;
	endfunction

	function automatic logic [8:0] turn_right(input logic [8:0] x);
		return {x[2], x[5], x[8], x[1], x[4], x[7], x[0], x[3], x[6]};
	endfunction

	function automatic logic [8:0] mirror_rows(input logic [8:0] x);
		return {x[2:0], x[5:3], x[8:6]};
	endfunction

	// Base pattern of a letter for a row of the letter table; zero where the letter is absent.
	function automatic logic [8:0] iso_base(input logic [1:0] row, input logic [3:0] letter);
		logic [8:0] r;
		r = '0;
		case (row)
			2'd0: if (letter < 4'd2) r = ISO_C1[letter[0]];
			2'd1: if (letter < 4'd6) r = ISO_C2[letter[2:0]];
			2'd2: if (letter < 4'd10) r = ISO_C3[letter];
			default: if (letter < 4'd13) r = ISO_C4[letter];
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/gcre_ram.sv
`default_nettype none

module gcre_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 512
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

`default_nettype wire

// File: rtl/generations_ca_cell_rule_engine.sv
// Channel | Dir | Handshake           | Word
// cmd     | in  | cmd_valid/cmd_stall | command, center_state, neighbor_alive, count,
//         |     |                     | survival, letter, positive
// res     | out | res_valid/res_stall | next_state, bad_letter
// cfg     | in  | cfg_we              | cfg_index, cfg_data
//
// Evaluate words are taken one per cycle unless the block is busy or res_stall backs up;
// each result passes through the lookup stage and the output register. A clear word sweeps
// the whole rule table, and a new count or an isotropic letter writes its entries; the table
// memory has a single write port. After reset the table is swept to zero with cmd_stall high.
// res_stall holds the output register; one further word waits in the lookup stage.
`default_nettype none
`include "generations_ca_cell_rule_engine_assert.svh"

module generations_ca_cell_rule_engine (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       cmd_valid,
	output logic            cmd_stall,
	input  wire logic [1:0] command,
	input  wire logic [7:0] center_state,
	input  wire logic [7:0] neighbor_alive,
	input  wire logic [3:0] count,
	input  wire logic       survival,
	input  wire logic [3:0] letter,
	input  wire logic       positive,
	output logic            res_valid,
	input  wire logic       res_stall,
	output logic      [7:0] next_state,
	output logic            bad_letter,
	input  wire logic       cfg_we,
	input  wire logic       cfg_index,
	input  wire logic [8:0] cfg_data
);

	import gcre_pkg::*;

	fsm_t state_q, state_nxt;

	logic [8:0] num_states_q;
	logic [8:0] mask_q;
	logic [8:0] sweep_q;
	logic [8:0] sweep_mask_q;
	logic [3:0] value_q;
	logic       surv_q;
	logic       pos_q;
	logic [8:0] pat_q;
	logic [DONE_W-1:0] done_q;

	logic       valid_s1;
	logic       eval_s1;
	logic       bad_s1;
	logic [7:0] center_s1;

	logic       res_valid_q;
	logic [7:0] next_state_q;
	logic       bad_letter_q;

	logic                 ram_we;
	logic [TBL_AW-1:0]    ram_waddr;
	logic [TBL_WIDTH-1:0] ram_wdata;
	logic                 ram_re;
	logic [TBL_AW-1:0]    ram_raddr;
	logic [TBL_WIDTH-1:0] ram_rdata;

	cmd_t       cmd;
	logic       accept;
	logic       adv;
	logic       sweep_last;
	logic       cnt_small;
	logic       cnt_mid;
	logic       is_total;
	logic [4:0] done_idx;
	logic       start_total;
	logic [2:0] row_raw;
	logic       mirrored;
	logic [1:0] row;
	logic       letter_bad;
	logic       letter_ok;
	logic       cmd_bad;
	logic [8:0] letter_pat;
	logic [8:0] sweep_pat;
	logic [8:0] aged;
	logic       hit;
	logic       ages;
	logic [7:0] next_s1;

	assign cmd = cmd_t'(command);

	// Output register advances when empty or being taken; the lookup stage feeds it.
	assign adv       = valid_s1 && (!res_valid_q || !res_stall);
	assign cmd_stall = !(state_q == ST_IDLE && (!valid_s1 || adv));
	assign accept    = cmd_valid && !cmd_stall;

	// Command decode.
	assign cnt_small = count <= 4'd8;
	assign cnt_mid   = count != 4'd0 && count < 4'd8;
	assign is_total  = (cmd == CMD_COUNT && cnt_small) ||
		(cmd == CMD_LETTER && (count == 4'd0 || count == 4'd8));
	assign done_idx  = 5'(count) + (survival ? 5'd9 : 5'd0);
	assign start_total = is_total && !done_q[done_idx];

	// Counts five to seven reuse the rows of three down to one with the pattern inverted.
	assign row_raw    = 3'(count - 4'd1);
	assign mirrored   = row_raw > 3'd3;
	assign row        = mirrored ? 2'(3'd6 - row_raw) : row_raw[1:0];
	assign letter_bad = letter >= ISO_LEN[row];
	assign letter_ok  = cmd == CMD_LETTER && cnt_mid && !letter_bad;
	assign cmd_bad    = cmd == CMD_LETTER && (!cnt_small || (cnt_mid && letter_bad));
	assign letter_pat = (iso_base(row, letter) ^ (mirrored ? MIRROR_XOR : 9'd0)) |
		(survival ? CENTER_BIT : 9'd0);

	assign sweep_pat = {sweep_q[7:4], 1'b0, sweep_q[3:0]};

	always_comb begin
		unique case (state_q)
			ST_CLEAR:  sweep_last = sweep_q == 9'd511;
			ST_TOTAL:  sweep_last = sweep_q[7:0] == 8'd255;
			ST_LETTER: sweep_last = sweep_q[2:0] == 3'd7;
			default:   sweep_last = 1'b0;
		endcase
	end

	// Next state.
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (accept) begin
					if (cmd == CMD_CLEAR) begin
						state_nxt = ST_CLEAR;
					end else if (start_total) begin
						state_nxt = ST_TOTAL;
					end else if (letter_ok) begin
						state_nxt = ST_LETTER;
					end
				end
			end
			ST_CLEAR, ST_TOTAL, ST_LETTER: begin
				if (sweep_last) begin
					state_nxt = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	// Table write port per state.
	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = sweep_q;
		ram_wdata = '0;
		unique case (state_q)
			ST_CLEAR: begin
				ram_we = 1'b1;
			end
			ST_TOTAL: begin
				ram_we    = pop9(sweep_pat & sweep_mask_q) == value_q;
				ram_waddr = {sweep_q[7:4], surv_q, sweep_q[3:0]};
				ram_wdata = 1'b1;
			end
			ST_LETTER: begin
				ram_we    = 1'b1;
				ram_waddr = pat_q;
				ram_wdata = pos_q;
			end
			default: ram_we = 1'b0;
		endcase
	end

	assign ram_re    = accept && cmd == CMD_EVAL;
	assign ram_raddr = {neighbor_alive[7:4], center_state == 8'd1, neighbor_alive[3:0]};

	gcre_ram #(
		.WIDTH(TBL_WIDTH),
		.DEPTH(TBL_DEPTH)
	) u_table (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_CLEAR;
			sweep_q      <= '0;
			done_q       <= '0;
			num_states_q <= NS_RESET;
			mask_q       <= MASK_RESET;
		end else begin
			state_q <= state_nxt;
			if (state_q != ST_IDLE) begin
				sweep_q <= sweep_q + 9'd1;
			end else begin
				sweep_q <= '0;
			end
			if (accept) begin
				if (cmd == CMD_CLEAR) begin
					done_q <= '0;
				end else if (start_total || letter_ok) begin
					done_q[done_idx] <= 1'b1;
				end
			end
			if (cfg_we) begin
				unique case (cfg_idx_t'(cfg_index))
					CFG_NUM_STATES:    num_states_q <= cfg_data;
					CFG_NEIGHBOR_MASK: mask_q       <= cfg_data;
				endcase
			end
		end
	end

	// Sweep operands; the mask is captured so that a later register write cannot disturb a sweep.
	always_ff @(posedge clk) begin
		if (accept) begin
			sweep_mask_q <= mask_q;
			value_q      <= count;
			surv_q       <= survival;
			pos_q        <= positive;
			pat_q        <= letter_pat;
		end else if (state_q == ST_LETTER) begin
			if (sweep_q[1:0] == 2'd3) begin
				pat_q <= mirror_rows(turn_right(pat_q));
			end else begin
				pat_q <= turn_right(pat_q);
			end
		end
	end

	// Lookup stage.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			eval_s1   <= cmd == CMD_EVAL;
			bad_s1    <= cmd_bad;
			center_s1 <= center_state;
		end
	end

	assign aged = {1'b0, center_s1} + 9'd1;
	assign hit  = center_s1 <= 8'd1 && ram_rdata[0];
	assign ages = center_s1 != 8'd0 && aged < num_states_q && center_s1 != 8'd255;

	always_comb begin
		if (!eval_s1) begin
			next_s1 = 8'd0;
		end else if (hit) begin
			next_s1 = 8'd1;
		end else if (ages) begin
			next_s1 = aged[7:0];
		end else begin
			next_s1 = 8'd0;
		end
	end

	// Output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (adv) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			next_state_q <= next_s1;
			bad_letter_q <= bad_s1 && !eval_s1;
		end
	end

	assign res_valid  = res_valid_q;
	assign next_state = next_state_q;
	assign bad_letter = bad_letter_q;

	`GCRE_ASSERT_NOW(a_no_rw_overlap, ram_re, !ram_we, "table read overlaps a table write")
	`GCRE_ASSERT_NEXT(a_clear_done, accept && cmd == CMD_CLEAR, done_q == '0,
		"done bits not cleared by a clear word")
	`GCRE_ASSERT_NEXT(a_bad_idle, accept && cmd_bad, state_q == ST_IDLE,
		"rejected letter started a table sweep")
	`GCRE_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv, valid_s1 && $stable(center_s1),
		"lookup stage lost its word while blocked")

endmodule

`default_nettype wire

// File: tb/tb_generations_ca_cell_rule_engine.sv
`timescale 1ns / 100ps

module tb_generations_ca_cell_rule_engine;
	import gcre_pkg::*;

	localparam int unsigned CYCLE_LIMIT = 800000;
	localparam int HOLD_CYCLES = 300;
	// A clear keeps the table port busy for its whole table sweep, which can outlast its result.
	localparam int SETTLE_CYCLES = 600;
	localparam int RANDOM_ITEMS = 1950;
	localparam int DIR_ROWS = 25;

	typedef struct packed {
		cmd_t       op;
		logic [7:0] center;
		logic [7:0] nbrs;
		logic [3:0] cnt;
		logic       surv;
		logic [3:0] ltr;
		logic       pos;
	} cell_word_t;

	typedef struct packed {
		logic [7:0] nxt;
		logic       bad;
	} cell_result_t;

	typedef struct packed {
		cmd_t       op;
		logic [7:0] center;
		logic [7:0] nbrs;
		logic [3:0] cnt;
		logic       surv;
		logic [3:0] ltr;
		logic       pos;
		logic       chk;
		logic [7:0] nxt;
		logic       bad;
	} dir_row_t;

	// Base shape of each isotropic letter, one table per neighbour count from one to four.
	localparam logic [8:0] SHAPE_R1 [2]  = '{9'd1, 9'd2};
	localparam logic [8:0] SHAPE_R2 [6]  = '{9'd5, 9'd10, 9'd3, 9'd40, 9'd33, 9'd68};
	localparam logic [8:0] SHAPE_R3 [10] = '{9'd69, 9'd42, 9'd11, 9'd7, 9'd98, 9'd13, 9'd14,
		9'd70, 9'd41, 9'd97};
	localparam logic [8:0] SHAPE_R4 [13] = '{9'd325, 9'd170, 9'd15, 9'd45, 9'd99, 9'd71,
		9'd106, 9'd102, 9'd43, 9'd101, 9'd105, 9'd78, 9'd108};

	logic       clk;
	logic       arst_n = 1'b0;
	logic       cmd_valid = 1'b0;
	logic       cmd_stall;
	logic [1:0] command = 2'd0;
	logic [7:0] center_state = 8'd0;
	logic [7:0] neighbor_alive = 8'd0;
	logic [3:0] count = 4'd0;
	logic       survival = 1'b0;
	logic [3:0] letter = 4'd0;
	logic       positive = 1'b0;
	logic       res_valid;
	logic       res_stall = 1'b0;
	logic [7:0] next_state;
	logic       bad_letter;
	logic       cfg_we = 1'b0;
	logic       cfg_index = 1'b0;
	logic [8:0] cfg_data = 9'd0;

	generations_ca_cell_rule_engine uut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.command(command),
		.center_state(center_state),
		.neighbor_alive(neighbor_alive),
		.count(count),
		.survival(survival),
		.letter(letter),
		.positive(positive),
		.res_valid(res_valid),
		.res_stall(res_stall),
		.next_state(next_state),
		.bad_letter(bad_letter),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	// Our own copy of the rule state and registers.
	bit          rule_bits [512];
	logic [17:0] done_mask;
	logic [8:0]  cur_states;
	logic [8:0]  cur_mask;

	cell_result_t outcomes_due [$];
	int          fail_count = 0;
	int          words_sent = 0;
	int          evals_sent = 0;
	int          rand_items = 0;
	int          phases_run = 0;
	int          holds_done = 0;
	int          burst_left = 0;
	int unsigned cycle_count = 0;
	bit          hold_req = 1'b0;
	bit          hold_active = 1'b0;

	dir_row_t dir_rows [DIR_ROWS] = '{
		'{CMD_EVAL,   8'd0,   8'h00, 4'd0,  1'b0, 4'd0,  1'b0, 1'b1, 8'd0, 1'b0},
		'{CMD_EVAL,   8'd1,   8'hff, 4'd0,  1'b0, 4'd0,  1'b0, 1'b1, 8'd2, 1'b0},
		'{CMD_EVAL,   8'd2,   8'h55, 4'd0,  1'b0, 4'd0,  1'b0, 1'b1, 8'd0, 1'b0},
		'{CMD_EVAL,   8'd255, 8'haa, 4'd0,  1'b0, 4'd0,  1'b0, 1'b1, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd15, 1'b1, 4'd0,  1'b1, 1'b1, 8'd0, 1'b1},
		'{CMD_COUNT,  8'd0,   8'h00, 4'd9,  1'b0, 4'd0,  1'b0, 1'b1, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd1,  1'b0, 4'd2,  1'b1, 1'b1, 8'd0, 1'b1},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd4,  1'b1, 4'd15, 1'b1, 1'b1, 8'd0, 1'b1},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd2,  1'b0, 4'd6,  1'b0, 1'b1, 8'd0, 1'b1},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd3,  1'b1, 4'd10, 1'b1, 1'b1, 8'd0, 1'b1},
		'{CMD_COUNT,  8'd0,   8'h00, 4'd3,  1'b0, 4'd0,  1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_COUNT,  8'd0,   8'h00, 4'd3,  1'b0, 4'd0,  1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_EVAL,   8'd0,   8'h07, 4'd0,  1'b0, 4'd0,  1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd0,  1'b1, 4'd12, 1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd8,  1'b0, 4'd15, 1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd2,  1'b1, 4'd5,  1'b1, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd3,  1'b0, 4'd9,  1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd5,  1'b1, 4'd9,  1'b1, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd6,  1'b0, 4'd5,  1'b1, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd7,  1'b1, 4'd1,  1'b1, 1'b0, 8'd0, 1'b0},
		'{CMD_LETTER, 8'd0,   8'h00, 4'd4,  1'b0, 4'd12, 1'b1, 1'b0, 8'd0, 1'b0},
		'{CMD_EVAL,   8'd1,   8'hff, 4'd0,  1'b0, 4'd0,  1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_EVAL,   8'd0,   8'he0, 4'd0,  1'b0, 4'd0,  1'b0, 1'b0, 8'd0, 1'b0},
		'{CMD_CLEAR,  8'd0,   8'h00, 4'd0,  1'b0, 4'd0,  1'b0, 1'b1, 8'd0, 1'b0},
		'{CMD_EVAL,   8'd0,   8'h07, 4'd0,  1'b0, 4'd0,  1'b0, 1'b1, 8'd0, 1'b0}
	};

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		forever begin
			@(posedge clk);
			cycle_count++;
			if (cycle_count >= CYCLE_LIMIT) begin
				$display("Timed out after %0d cycles with %0d results outstanding.",
					cycle_count, outcomes_due.size());
				$display("CHECKS FAILED");
				$finish;
			end
		end
	end

	function automatic logic [8:0] rotate_cw(input logic [8:0] x);
		logic [8:0] r;
		r[8] = x[2];
		r[7] = x[5];
		r[6] = x[8];
		r[5] = x[1];
		r[4] = x[4];
		r[3] = x[7];
		r[2] = x[0];
		r[1] = x[3];
		r[0] = x[6];
		return r;
	endfunction

	// Counts five to seven reuse the shapes of three to one, complemented.
	function automatic int row_of(input int cnt);
		return (cnt <= 4) ? cnt - 1 : 7 - cnt;
	endfunction

	function automatic int letter_limit(input int row);
		case (row)
			0: return 2;
			1: return 6;
			2: return 10;
			default: return 13;
		endcase
	endfunction

	task automatic fill_count(input int value, input logic surv);
		int bitno;
		logic [8:0] p9;
		bitno = value + (surv ? 9 : 0);
		if (done_mask[bitno])
			return;
		done_mask[bitno] = 1'b1;
		for (int p = 0; p < 512; p++) begin
			p9 = 9'(p);
			if (!p9[4] && $countones(p9 & cur_mask) == value)
				rule_bits[p9 | (surv ? 9'h010 : 9'h000)] = 1'b1;
		end
	endtask

	task automatic cell_outcome(input cell_word_t w, output cell_result_t res);
		int cnt;
		int row;
		int c;
		logic [8:0] y;
		res = '0;
		cnt = int'(w.cnt);
		case (w.op)
			CMD_CLEAR: begin
				foreach (rule_bits[i])
					rule_bits[i] = 1'b0;
				done_mask = '0;
			end
			CMD_COUNT: begin
				if (cnt <= 8)
					fill_count(cnt, w.surv);
			end
			CMD_LETTER: begin
				if (cnt > 8) begin
					res.bad = 1'b1;
				end else if (cnt == 0 || cnt == 8) begin
					fill_count(cnt, w.surv);
				end else begin
					row = row_of(cnt);
					if (int'(w.ltr) >= letter_limit(row)) begin
						res.bad = 1'b1;
					end else begin
						done_mask[cnt + (w.surv ? 9 : 0)] = 1'b1;
						case (row)
							0: y = SHAPE_R1[w.ltr];
							1: y = SHAPE_R2[w.ltr];
							2: y = SHAPE_R3[w.ltr];
							default: y = SHAPE_R4[w.ltr];
						endcase
						if (cnt > 4)
							y = y ^ 9'h1ef;
						if (w.surv)
							y = y | 9'h010;
						// Four turns bring the shape home, then the mirrored set follows.
						for (int i = 0; i < 8; i++) begin
							if (i == 4)
								y = {y[2:0], y[5:3], y[8:6]};
							rule_bits[y] = w.pos;
							y = rotate_cw(y);
						end
					end
				end
			end
			default: begin
				c = int'(w.center);
				if (c <= 1 && rule_bits[{w.nbrs[7:4], c == 1, w.nbrs[3:0]}])
					res.nxt = 8'd1;
				else if (c > 0 && c + 1 < int'(cur_states) && c < 255)
					res.nxt = 8'(c + 1);
				else
					res.nxt = 8'd0;
			end
		endcase
	endtask

	always @(posedge clk) begin
		cell_result_t want;
		if (arst_n && res_valid === 1'b1 && res_stall === 1'b0) begin
			if (outcomes_due.size() == 0) begin
				$error("Result with nothing outstanding: next_state %0d, bad_letter %0d",
					next_state, bad_letter);
				fail_count++;
			end else begin
				want = outcomes_due.pop_front();
				if (next_state !== want.nxt) begin
					$error("next_state: expected %0d, got %0d", want.nxt, next_state);
					fail_count++;
				end
				if (bad_letter !== want.bad) begin
					$error("bad_letter: expected %0d, got %0d", want.bad, bad_letter);
					fail_count++;
				end
			end
		end
	end

	// Result side: stall patterns that change every so often, plus a long hold-off on request.
	initial begin
		int mode;
		int len;
		forever begin
			mode = $urandom_range(0, 3);
			len = $urandom_range(20, 200);
			for (int i = 0; i < len && !hold_req; i++) begin
				@(negedge clk);
				case (mode)
					0: res_stall <= 1'b0;
					1: res_stall <= ($urandom_range(0, 99) < 30);
					2: res_stall <= (i % 4 == 0);
					default: res_stall <= ($urandom_range(0, 99) < 70);
				endcase
			end
			if (hold_req) begin
				hold_active = 1'b1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					res_stall <= 1'b1;
				end
				hold_active = 1'b0;
				hold_req = 1'b0;
				holds_done++;
			end
		end
	end

	task automatic idle_cycles(input int n);
		repeat (n) begin
			@(negedge clk);
			cmd_valid <= 1'b0;
		end
	endtask

	task automatic write_reg(input cfg_idx_t idx, input logic [8:0] val);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx == CFG_NUM_STATES)
			cur_states = val;
		else
			cur_mask = val;
	endtask

	// Bring the block to rest: every result back and the table port finished.
	task automatic settle_block();
		idle_cycles(1);
		while (outcomes_due.size() != 0)
			idle_cycles(1);
		idle_cycles(SETTLE_CYCLES);
	endtask

	task automatic send(input cell_word_t w, input logic fixed, input cell_result_t fixed_res);
		cell_result_t res;
		int gap;
		if (burst_left == 0) begin
			burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(100, 300)
				: $urandom_range(1, 16);
			gap = $urandom_range(0, 5);
			if (gap > 0)
				idle_cycles(gap);
		end
		burst_left--;
		@(negedge clk);
		cmd_valid <= 1'b1;
		command <= w.op;
		center_state <= w.center;
		neighbor_alive <= w.nbrs;
		count <= w.cnt;
		survival <= w.surv;
		letter <= w.ltr;
		positive <= w.pos;
		@(posedge clk);
		while (cmd_stall !== 1'b0)
			@(posedge clk);
		cell_outcome(w, res);
		outcomes_due.push_back(fixed ? fixed_res : res);
		words_sent++;
		if (w.op == CMD_EVAL)
			evals_sent++;
	endtask

	function automatic cell_word_t rand_eval();
		cell_word_t w;
		int pick;
		w.op = CMD_EVAL;
		w.nbrs = 8'($urandom);
		w.cnt = 4'($urandom);
		w.surv = 1'($urandom);
		w.ltr = 4'($urandom);
		w.pos = 1'($urandom);
		pick = $urandom_range(0, 9);
		if (pick < 4)
			w.center = 8'd0;
		else if (pick < 8)
			w.center = 8'd1;
		else if (pick == 8)
			w.center = 8'($urandom);
		else
			w.center = 8'($urandom_range(250, 255));
		return w;
	endfunction

	function automatic cell_word_t rand_rule(input logic noisy);
		cell_word_t w;
		int cnt;
		w.center = 8'($urandom);
		w.nbrs = 8'($urandom);
		w.surv = 1'($urandom);
		w.pos = ($urandom_range(0, 3) != 0);
		w.ltr = 4'($urandom);
		if (!noisy) begin
			cnt = $urandom_range(0, 8);
			w.cnt = 4'(cnt);
			w.op = $urandom_range(0, 1) ? CMD_COUNT : CMD_LETTER;
			if (w.op == CMD_LETTER && cnt >= 1 && cnt <= 7)
				w.ltr = 4'($urandom_range(0, letter_limit(row_of(cnt)) - 1));
		end else begin
			case ($urandom_range(0, 2))
				0: begin
					w.op = CMD_COUNT;
					w.cnt = 4'($urandom_range(9, 15));
				end
				1: begin
					w.op = CMD_LETTER;
					w.cnt = 4'($urandom_range(9, 15));
				end
				default: begin
					w.op = CMD_LETTER;
					cnt = $urandom_range(1, 7);
					w.cnt = 4'(cnt);
					w.ltr = 4'($urandom_range(letter_limit(row_of(cnt)), 15));
				end
			endcase
		end
		return w;
	endfunction

	initial begin
		cell_word_t w;
		cell_word_t clr;
		dir_row_t r;
		logic [8:0] ns_val;
		logic [8:0] mask_val;
		logic noisy;
		int n_prog;
		int n_eval;
		int k;

		foreach (rule_bits[i])
			rule_bits[i] = 1'b0;
		done_mask = '0;
		cur_states = 9'd3;
		cur_mask = 9'd511;
		clr = '0;
		clr.op = CMD_CLEAR;

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Directed words run against the reset register values.
		for (int i = 0; i < DIR_ROWS; i++) begin
			r = dir_rows[i];
			w = '{r.op, r.center, r.nbrs, r.cnt, r.surv, r.ltr, r.pos};
			send(w, r.chk, '{r.nxt, r.bad});
		end

		while (rand_items < RANDOM_ITEMS) begin
			settle_block();
			case (phases_run)
				0: ns_val = 9'd2;
				1: ns_val = 9'd256;
				2: ns_val = 9'd3;
				3: ns_val = 9'd7;
				4: ns_val = 9'd255;
				default: ns_val = 9'($urandom_range(2, 256));
			endcase
			case (phases_run)
				0: mask_val = 9'd511;
				1: mask_val = 9'd0;
				2: mask_val = 9'h1ef;
				3: mask_val = 9'h010;
				default: mask_val = 9'($urandom_range(0, 511));
			endcase
			write_reg(CFG_NUM_STATES, ns_val);
			write_reg(CFG_NEIGHBOR_MASK, mask_val);

			if ($urandom_range(0, 3) != 0) begin
				send(clr, 1'b0, '0);
				rand_items++;
			end
			n_prog = $urandom_range(2, 8);
			for (int i = 0; i < n_prog; i++) begin
				noisy = ($urandom_range(0, 6) == 0);
				send(rand_rule(noisy), 1'b0, '0);
				if (!noisy)
					rand_items++;
			end

			// One phase parks the result side while words keep coming, so the input backs up.
			if (phases_run == 2) begin
				hold_req = 1'b1;
				wait (hold_active);
				while (holds_done == 0) begin
					send(rand_eval(), 1'b0, '0);
					rand_items++;
				end
			end

			n_eval = $urandom_range(60, 200);
			for (int i = 0; i < n_eval; i++) begin
				k = $urandom_range(0, 199);
				if (k == 0) begin
					send(clr, 1'b0, '0);
					rand_items++;
				end else if (k < 6) begin
					noisy = (k == 5);
					send(rand_rule(noisy), 1'b0, '0);
					if (!noisy)
						rand_items++;
				end else begin
					send(rand_eval(), 1'b0, '0);
					rand_items++;
				end
			end
			phases_run++;
		end

		idle_cycles(1);
		while (outcomes_due.size() != 0)
			idle_cycles(1);
		idle_cycles(40);

		$display("Sent %0d words (%0d evaluations) over %0d register settings.",
			words_sent, evals_sent, phases_run);
		$display("Result side held off %0d time(s); %0d mismatches seen.",
			holds_done, fail_count);
		if (fail_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// File: generations_ca_cell_rule_engine.f
+incdir+rtl
rtl/gcre_pkg.sv
rtl/gcre_ram.sv
rtl/generations_ca_cell_rule_engine.sv
tb/tb_generations_ca_cell_rule_engine.sv
